// ----- design/hlor_pkg.sv -----
// Shared widths, constants, types and the log table generator for the light residual pipeline.
package hlor_pkg;

  localparam int NORM_W = 47;  // magnitude width fed to the log unit
  localparam int P_W    = 6;   // leading-one position width
  localparam int LOG_W  = 22;  // log2 result width, Q.16
  localparam int TAB_W  = 17;  // table entry width, Q.16 up to 1.0
  localparam int CM_W   = 45;  // magnitude of the quenching term

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  typedef enum logic [1:0] {
    REG_OFFSET = 2'd0,
    REG_GAIN   = 2'd1,
    REG_COEFF  = 2'd2
  } reg_idx_t;

  // Per-event side information that rides along the arithmetic stages.
  typedef struct packed {
    logic            inv;
    logic            c_neg;
    logic [CM_W-1:0] cm;
    logic [23:0]     e;
    logic [19:0]     meas;
  } sb_t;

  // Entry i of log2(1 + i/2^tbits) in Q.16 by repeated squaring of a Q1.30 value.
  function automatic logic [TAB_W-1:0] lg_entry(input int unsigned i, input int unsigned tbits);
    logic [63:0] x;
    logic [31:0] res;
    x = (64'(1 << tbits) + 64'(i)) << (30 - tbits);
    res = '0;
    if (x >= (64'd2 << 30)) begin
      x = x >> 1;
      res = res + 32'd65536;
    end
    for (int k = 0; k < 16; k++) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        res = res | (32'd1 << (15 - k));
      end
    end
    return res[TAB_W-1:0];
  endfunction

endpackage

// ----- design/hlor_log2.sv -----
// Four-stage base-2 logarithm: leading-one search, normalize, table lookup, interpolate.
module hlor_log2 import hlor_pkg::*; #(
  parameter int TBITS = 8
) (
  input  logic              clk,
  input  logic [3:0]        en,
  input  logic [NORM_W-1:0] n,
  output logic [LOG_W-1:0]  lg
);

  localparam int TN = 1 << TBITS;

  logic [TAB_W-1:0] tab [TN+1];

  for (genvar i = 0; i <= TN; i++) begin : g_tab
    assign tab[i] = lg_entry(i, TBITS);
  end

  logic [P_W-1:0]    p_c, p1, p2, p3;
  logic [NORM_W-1:0] n1, norm;
  logic [TBITS-1:0]  idx2;
  logic [15:0]       w2;
  logic [TAB_W-1:0]  lo_c, hi_c, d_c, lo3, mh3;
  logic [32:0]       m_c;

  always_comb begin
    p_c = '0;
    for (int i = 1; i < NORM_W; i++) begin
      if (n[i]) p_c = P_W'(i);
    end
  end

  assign norm = n1 << (P_W'(NORM_W - 1) - p1);
  assign lo_c = tab[{1'b0, idx2}];
  assign hi_c = tab[(TBITS+1)'(idx2) + (TBITS+1)'(1)];
  assign d_c  = hi_c - lo_c;
  assign m_c  = 33'(d_c) * 33'(w2);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p1 <= p_c;
      n1 <= n;
    end
    if (en[1]) begin
      p2   <= p1;
      idx2 <= norm[NORM_W-2 -: TBITS];
      w2   <= norm[NORM_W-2-TBITS -: 16];
    end
    if (en[2]) begin
      p3  <= p2;
      lo3 <= lo_c;
      mh3 <= m_c[32:16];
    end
    if (en[3]) begin
      lg <= LOG_W'({p3, 16'b0}) + LOG_W'(lo3) + LOG_W'(mh3);
    end
  end

endmodule

// ----- design/horn_light_output_residual.sv -----
// Top level: Horn light formula and residual per event, sixteen-stage pipeline.
//
//  channel | direction | payload
//  s_*     | in        | s_tdata: energy[23:0], charge_z[27:24], mass_a[33:28], measured_signal[53:34]
//  m_*     | out       | m_tdata: computed_light[31:0], residual[63:32]; m_tuser: invalid
//  cfg_*   | in        | cfg_index selects offset, gain or coefficient; cfg_data is the value
//
// One request enters per cycle unless a stalled output has filled the pipeline.
// The stage count is set by the log unit (four stages per operand) and the chained multiplies.
// Reset clears the stage valid bits and loads the register defaults.
// A stall holds only the stages that are full; bubbles ahead of it still close up.
module horn_light_output_residual import hlor_pkg::*; #(
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // energy, charge_z, mass_a, measured_signal
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // computed_light, residual
  output logic [0:0]  m_tuser    // invalid
);

  localparam int NS = 16;

  logic signed [31:0] light_offset, light_gain, quench_coeff;

  logic [NS:1] v, en;

  logic [23:0] e1, e2, e3, e4;
  logic [3:0]  z1;
  logic [5:0]  a1, a2;
  logic [19:0] meas1, meas2, meas3, meas4;
  logic [7:0]  zsq2;
  logic [13:0] az3;
  logic signed [46:0] c4, sum_c;
  logic [NORM_W-1:0]  ns5, nc5;
  sb_t                sb [5:NS-1];
  logic [LOG_W-1:0]   lg_s, lg_c;

  logic signed [LOG_W:0] diff_c;
  logic [LOG_W-1:0]      dm_c, lnm10;
  logic [55:0]           lnp_c;
  logic                  ln_neg10, neg11;
  logic [50:0]           ph11;
  logic [37:0]           pl_c;
  logic [21:0]           pl11;
  logic [51:0]           ltm_c;
  logic signed [53:0]    e28_c, inner12, t13_c;
  logic signed [33:0]    inner13;
  logic signed [65:0]    prod14, tp_c;
  logic signed [32:0]    to_c;
  logic signed [46:0]    light15;
  logic signed [47:0]    res_c;

  function automatic logic [31:0] sat32(input logic signed [47:0] x);
    if (x > 48'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -48'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      light_offset <= 32'sd0;
      light_gain   <= 32'sd65536;
      quench_coeff <= 32'sd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET: light_offset <= cfg_data;
        REG_GAIN:   light_gain   <= cfg_data;
        REG_COEFF:  quench_coeff <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when the stage after it loads.
  always_comb begin
    en[NS] = !v[NS] || m_tready;
    for (int k = NS - 1; k >= 1; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  assign s_tready = en[1];
  assign m_tvalid = v[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= s_tvalid;
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  assign sum_c = $signed({3'b0, e4, 20'b0}) + c4;

  hlor_log2 #(.TBITS(LOG_TABLE_BITS)) u_log_sum (
    .clk (clk),
    .en  (en[9:6]),
    .n   (ns5),
    .lg  (lg_s)
  );

  hlor_log2 #(.TBITS(LOG_TABLE_BITS)) u_log_c (
    .clk (clk),
    .en  (en[9:6]),
    .n   (nc5),
    .lg  (lg_c)
  );

  assign diff_c = $signed({1'b0, lg_s}) - $signed({1'b0, lg_c});
  assign dm_c   = diff_c[LOG_W] ? LOG_W'(-diff_c) : diff_c[LOG_W-1:0];
  assign lnp_c  = 56'(dm_c) * 56'(LN2_Q32) + 56'h8000_0000;
  assign pl_c   = 38'(sb[10].cm[15:0]) * 38'(lnm10);
  assign ltm_c  = 52'(ph11) + 52'(pl11);
  assign e28_c  = $signed({10'b0, sb[11].e, 20'b0});
  // Rounding half away from zero: add half, less one for negative values, then shift.
  assign t13_c  = inner12 + 54'sh80000 - $signed({53'b0, inner12[53]});
  assign tp_c   = prod14 + 66'sh80000 - $signed({65'b0, prod14[65]});
  assign to_c   = 33'(light_offset) + 33'sh800 - $signed({32'b0, light_offset[31]});
  assign res_c  = $signed({28'b0, sb[15].meas}) - 48'(light15);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      e1    <= s_tdata[23:0];
      z1    <= s_tdata[27:24];
      a1    <= s_tdata[33:28];
      meas1 <= s_tdata[53:34];
    end
    if (en[2]) begin
      zsq2  <= 8'(z1) * 8'(z1);
      a2    <= a1;
      e2    <= e1;
      meas2 <= meas1;
    end
    if (en[3]) begin
      az3   <= 14'(a2) * 14'(zsq2);
      e3    <= e2;
      meas3 <= meas2;
    end
    if (en[4]) begin
      c4    <= 47'(quench_coeff) * $signed({33'b0, az3});
      e4    <= e3;
      meas4 <= meas3;
    end
    if (en[5]) begin
      ns5          <= sum_c[46] ? NORM_W'(-sum_c) : NORM_W'(sum_c);
      nc5          <= c4[46] ? NORM_W'(-c4) : NORM_W'(c4);
      sb[5].inv    <= (c4 == 47'sd0) || (sum_c == 47'sd0);
      sb[5].c_neg  <= c4[46];
      sb[5].cm     <= c4[46] ? CM_W'(-c4) : CM_W'(c4);
      sb[5].e      <= e4;
      sb[5].meas   <= meas4;
    end
    for (int k = 6; k <= NS - 1; k++) begin
      if (en[k]) sb[k] <= sb[k-1];
    end
    if (en[10]) begin
      lnm10    <= lnp_c[32 +: LOG_W];
      ln_neg10 <= diff_c[LOG_W];
    end
    if (en[11]) begin
      ph11  <= 51'(sb[10].cm[44:16]) * 51'(lnm10);
      pl11  <= pl_c[37:16];
      neg11 <= sb[10].c_neg ^ ln_neg10;
    end
    if (en[12]) begin
      inner12 <= neg11 ? e28_c + $signed({2'b0, ltm_c}) : e28_c - $signed({2'b0, ltm_c});
    end
    if (en[13]) begin
      inner13 <= 34'(t13_c >>> 20);
    end
    if (en[14]) begin
      prod14 <= 66'(light_gain) * 66'(inner13);
    end
    if (en[15]) begin
      light15 <= 47'(46'(tp_c >>> 20)) + 47'(21'(to_c >>> 12));
    end
    if (en[16]) begin
      m_tdata[31:0]  <= sb[15].inv ? 32'b0 : sat32(48'(light15));
      m_tdata[63:32] <= sb[15].inv ? 32'b0 : sat32(res_c);
      m_tuser        <= sb[15].inv;
    end
  end

endmodule

// ----- test/horn_light_output_residual_tb.sv -----
// Testbench for the Horn light-output residual block: directed and random events against a predictor.
`timescale 1ns / 100ps

class light_scoreboard;
  logic [63:0] pending_light[$];
  logic        pending_inv[$];
  int          errors;
  int          checked;
  int          invalid_seen;

  function new();
    errors = 0;
    checked = 0;
    invalid_seen = 0;
  endfunction

  function void note_request(logic [63:0] light_pair, logic inv);
    pending_light = {pending_light, light_pair};
    pending_inv = {pending_inv, inv};
  endfunction

  function void check_result(logic [63:0] got_pair, logic got_inv);
    logic [63:0] exp_pair;
    logic        exp_inv;
    if (pending_light.size() == 0) begin
      $display("%0t: unexpected result light=%h residual=%h invalid=%b", $time,
               got_pair[31:0], got_pair[63:32], got_inv);
      errors++;
      return;
    end
    exp_pair = pending_light.pop_front();
    exp_inv = pending_inv.pop_front();
    checked++;
    if (exp_inv) invalid_seen++;
    if (got_pair[31:0] !== exp_pair[31:0]) begin
      $display("%0t: computed_light expected %h actual %h", $time, exp_pair[31:0], got_pair[31:0]);
      errors++;
    end
    if (got_pair[63:32] !== exp_pair[63:32]) begin
      $display("%0t: residual expected %h actual %h", $time, exp_pair[63:32], got_pair[63:32]);
      errors++;
    end
    if (got_inv !== exp_inv) begin
      $display("%0t: invalid expected %b actual %b", $time, exp_inv, got_inv);
      errors++;
    end
  endfunction
endclass

module horn_light_output_residual_tb import hlor_pkg::*; ();

  localparam int TBITS = 8;
  localparam int DEPTH = 16;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [55:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;

  light_scoreboard sb;
  logic [31:0] log_rom[0:(1 << TBITS)];
  logic signed [63:0] offset_q16, gain_q16, coeff_q28;
  int          sent;

  horn_light_output_residual #(.LOG_TABLE_BITS(TBITS)) uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Table of log2(1 + i/2^TBITS) in Q.16 by repeated squaring, truncated each step.
  initial begin
    logic [63:0] x;
    logic [31:0] acc;
    for (int i = 0; i <= (1 << TBITS); i++) begin
      x = (64'(1 << TBITS) + 64'(i)) << (30 - TBITS);
      acc = 0;
      while (x >= (64'd2 << 30)) begin
        x = x >> 1;
        acc = acc + 32'd65536;
      end
      for (int k = 0; k < 16; k++) begin
        x = (x * x) >> 30;
        if (x >= (64'd2 << 30)) begin
          x = x >> 1;
          acc = acc | (32'd1 << (15 - k));
        end
      end
      log_rom[i] = acc;
    end
  end

  function automatic logic signed [63:0] round_shift(logic signed [63:0] v, int s);
    logic [63:0] m;
    m = v < 0 ? -v : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return v < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic logic signed [63:0] log2_fixed(logic [63:0] n);
    int p;
    logic [63:0] f, w, lo, hi;
    int idx;
    p = 46;
    while (p > 0 && n[p] == 1'b0) p--;
    f = (n << (62 - p)) & ((64'd1 << 62) - 1);
    idx = int'(f >> (62 - TBITS));
    w = (f >> (46 - TBITS)) & 64'hFFFF;
    lo = log_rom[idx];
    hi = log_rom[idx + 1];
    return $signed(64'(p) * 64'd65536 + lo + (((hi - lo) * w) >> 16));
  endfunction

  function automatic void horn_light(input logic [23:0] e, input logic [3:0] z,
                                     input logic [5:0] a, input logic [19:0] meas,
                                     output logic [63:0] pair, output logic inv);
    logic signed [63:0] c28, e28, sum, diff, ln16, lt28, inner8, prod, light;
    logic signed [63:0] light_sat, res_sat;
    logic [63:0] lnm, cm, ltm, dm;
    c28 = coeff_q28 * $signed(64'(a) * 64'(z) * 64'(z));
    e28 = $signed(64'(e) << 20);
    sum = e28 + c28;
    if (c28 == 0 || sum == 0) begin
      pair = '0;
      inv = 1'b1;
      return;
    end
    diff = log2_fixed(sum < 0 ? -sum : sum) - log2_fixed(c28 < 0 ? -c28 : c28);
    dm = diff < 0 ? -diff : diff;
    lnm = (dm * 64'd2977044472 + (64'd1 << 31)) >> 32;
    ln16 = diff < 0 ? -$signed(lnm) : $signed(lnm);
    cm = c28 < 0 ? -c28 : c28;
    ltm = (cm >> 16) * lnm + (((cm & 64'hFFFF) * lnm) >> 16);
    lt28 = ((c28 < 0) != (ln16 < 0)) ? -$signed(ltm) : $signed(ltm);
    inner8 = round_shift(e28 - lt28, 20);
    prod = gain_q16 * inner8;
    light = round_shift(prod, 20) + round_shift(offset_q16, 12);
    light_sat = clamp32(light);
    res_sat = clamp32($signed(64'(meas)) - light);
    pair = {res_sat[31:0], light_sat[31:0]};
    inv = 1'b0;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_OFFSET: offset_q16 = $signed(val);
      REG_GAIN:   gain_q16 = $signed(val);
      REG_COEFF:  coeff_q28 = $signed(val);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Unknown register indexes must leave every setting alone.
  task automatic write_unused(logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= 2'd3;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // The sender goes idle and waits until every expected result is back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending_light.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
  endtask

  task automatic send_event(logic [23:0] e, logic [3:0] z, logic [5:0] a, logic [19:0] meas);
    logic [63:0] pair;
    logic inv;
    int gap;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {2'b00, meas, a, z, e};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    horn_light(e, z, a, meas, pair, inv);
    sb.note_request(pair, inv);
    sent++;
  endtask

  function automatic logic [23:0] pick_energy();
    case ($urandom_range(0, 5))
      0: return 24'(0);
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(0, 255));
      3: return 24'($urandom_range(0, 65535));
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_coeff();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($urandom_range(1, 1 << 20));
      3: return -32'($urandom_range(1, 1 << 20));
      default: return $urandom;
    endcase
  endfunction

  // Receiver with random stalls, mostly short, sometimes long.
  initial begin
    int stall;
    stall = 0;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser[0]);
      if (stall > 0) begin
        stall--;
      end else begin
        stall = ($urandom_range(0, 9) < 7) ? 0 :
                (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
      end
      m_tready <= (stall == 0);
    end
  end

  initial begin
    sb = new();
    sent = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_OFFSET;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    offset_q16 = 0;
    gain_q16 = 65536;
    coeff_q28 = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: zero coefficient makes every event invalid.
    send_event(24'd100, 4'd1, 6'd1, 20'd5);
    drain();
    write_reg(REG_COEFF, 32'h00100000);
    write_reg(REG_OFFSET, 32'h00012345);
    send_event(24'd0, 4'd1, 6'd1, 20'd0);
    send_event(24'hFFFFFF, 4'd15, 6'd63, 20'hFFFFF);
    send_event(24'd1, 4'd15, 6'd1, 20'd0);
    send_event(24'h800000, 4'd8, 6'd32, 20'h80000);
    drain();
    write_reg(REG_COEFF, 32'hFFF00000);
    // Energy that cancels the negative term gives a zero log argument.
    send_event(24'd1, 4'd1, 6'd1, 20'd7);
    send_event(24'd2, 4'd1, 6'd1, 20'd7);
    send_event(24'hFFFFFF, 4'd15, 6'd63, 20'd0);
    send_event(24'd0, 4'd2, 6'd3, 20'h12345);
    drain();
    write_reg(REG_GAIN, 32'h7FFFFFFF);
    write_reg(REG_OFFSET, 32'h7FFFFFFF);
    write_reg(REG_COEFF, 32'h7FFFFFFF);
    send_event(24'hFFFFFF, 4'd15, 6'd63, 20'd0);
    send_event(24'hFFFFFF, 4'd1, 6'd1, 20'hFFFFF);
    send_event(24'd0, 4'd1, 6'd1, 20'hFFFFF);
    drain();
    write_reg(REG_GAIN, 32'h80000000);
    write_reg(REG_OFFSET, 32'h80000000);
    write_reg(REG_COEFF, 32'h80000000);
    write_unused(32'h0BADF00D);
    send_event(24'hFFFFFF, 4'd15, 6'd63, 20'hFFFFF);
    send_event(24'h123456, 4'd7, 6'd21, 20'h54321);
    send_event(24'd0, 4'd15, 6'd63, 20'd0);
    drain();

    for (int phase = 0; phase < 10; phase++) begin
      write_reg(REG_OFFSET, ($urandom_range(0, 3) == 0) ? $urandom : 32'($signed(
                $urandom_range(0, 1 << 22)) - (1 << 21)));
      write_reg(REG_GAIN, ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 1 << 18)));
      write_reg(REG_COEFF, pick_coeff());
      for (int n = 0; n < 153; n++) begin
        send_event(pick_energy(), 4'($urandom_range(1, 15)), 6'($urandom_range(1, 63)),
                   20'($urandom));
      end
      drain();
    end

    $display("Ran %0d events under the reset values, four directed settings with extremes", sent);
    $display("and ten random settings; %0d results checked, %0d of them invalid.",
             sb.checked, sb.invalid_seen);
    if (sb.errors == 0 && sb.pending_light.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end
endmodule

// ----- horn_light_output_residual.f -----
design/hlor_pkg.sv
design/hlor_log2.sv
design/horn_light_output_residual.sv
test/horn_light_output_residual_tb.sv
